/* hdl/pfsc_pkg.sv */
package pfsc_pkg;

    // Sample format codes
    localparam logic [2:0] FMT_I16 = 3'd0;
    localparam logic [2:0] FMT_I24 = 3'd1;
    localparam logic [2:0] FMT_I32 = 3'd2;
    localparam logic [2:0] FMT_F32 = 3'd3;
    localparam logic [2:0] FMT_F64 = 3'd4;

    // Function codes
    localparam logic FUNC_DECODE = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    // Decode path kinds
    localparam logic [1:0] K_BYP = 2'd0;
    localparam logic [1:0] K_INT = 2'd1;
    localparam logic [1:0] K_F64 = 2'd2;

    typedef struct packed {
        logic        func;
        logic [2:0]  sample_format;
        logic [63:0] native_sample;
        logic [31:0] float_sample;
    } t_in_item;

    typedef struct packed {
        logic [31:0] float_result;
        logic [63:0] native_result;
        logic        native_valid;
    } t_out_item;

    // Index of the highest set bit (0 when none)
    function automatic logic [4:0] f_msb32(input logic [31:0] x);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) p = 5'(i);
        end
        return p;
    endfunction

    function automatic logic [4:0] f_msb23(input logic [22:0] x);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (x[i]) p = 5'(i);
        end
        return p;
    endfunction

    // Bit length of a 56-bit value
    function automatic logic [5:0] f_blen56(input logic [55:0] x);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 56; i++) begin
            if (x[i]) n = 6'(i + 1);
        end
        return n;
    endfunction

    // Exact widening of binary32 to binary64; NaNs come out quiet
    function automatic logic [63:0] f_f32_to_f64(input logic [31:0] x);
        logic [7:0]  e;
        logic [22:0] f;
        logic [4:0]  p;
        logic [74:0] fs;
        logic [63:0] r;
        e  = x[30:23];
        f  = x[22:0];
        p  = f_msb23(f);
        fs = {52'd0, f} << (6'd52 - {1'b0, p});
        if (e == 8'hFF) begin
            if (f == 23'd0) r = {x[31], 11'h7FF, 52'd0};
            else            r = {x[31], 11'h7FF, 1'b1, f[21:0], 29'd0};
        end else if (e == 8'd0) begin
            if (f == 23'd0) r = {x[31], 63'd0};
            else            r = {x[31], 11'(p) + 11'd874, fs[51:0]};
        end else begin
            r = {x[31], {3'd0, e} + 11'd896, f, 29'd0};
        end
        return r;
    endfunction

endpackage

/* hdl/pfsc_in_if.sv */
interface pfsc_in_if import pfsc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/pfsc_out_if.sv */
interface pfsc_out_if import pfsc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/pcm_float_sample_converter_top.sv */
// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   func, sample_format, native_sample, float_sample
// o_out     out  valid/ready   float_result, native_result, native_valid
//
// Five register stages; one item per cycle while o_out is not stalled.
// Stage split: operand prep, scale/leading-one, align shift, round, final shift.
// i_rst_n (synchronous) clears the stage valid bits only.
// A stall at o_out freezes every stage; i_in.ready is low only while the
// last stage holds an item that is not being taken.
module pcm_float_sample_converter_top import pfsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfsc_in_if.sink     i_in,
    pfsc_out_if.source  o_out
);

    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // ---------------- stage 1: operand prep ----------------
    logic [32:0] s1_sx, s1_mag;
    logic [7:0]  s1_ebase;
    logic [1:0]  s1_kind;
    logic [31:0] s1_byp;
    logic [52:0] s1_frac;
    logic        s1_sign;
    logic [10:0] s1_e;
    logic [30:0] s1_emag;
    logic        s1_nan;

    always_comb begin
        s1_sx = {i_in.data.native_sample[31], i_in.data.native_sample[31:0]};
        s1_ebase = 8'd95;
        case (i_in.data.sample_format)
            FMT_I16: begin
                s1_sx = {{17{i_in.data.native_sample[15]}}, i_in.data.native_sample[15:0]};
                s1_ebase = 8'd111;
            end
            FMT_I24: begin
                s1_sx = {{9{i_in.data.native_sample[23]}}, i_in.data.native_sample[23:0]};
                s1_ebase = 8'd103;
            end
            default: ;
        endcase
        s1_mag = s1_sx[32] ? (~s1_sx + 33'd1) : s1_sx;
        s1_e = i_in.data.native_sample[62:52];

        s1_kind = K_BYP;
        s1_byp  = 32'd0;
        s1_frac = {1'b1, i_in.data.native_sample[51:0]};
        s1_sign = i_in.data.native_sample[63];
        if (i_in.data.func == FUNC_ENCODE) begin
            s1_sign = i_in.data.float_sample[31];
        end else begin
            case (i_in.data.sample_format)
                FMT_I16, FMT_I24, FMT_I32: begin
                    s1_kind = K_INT;
                    s1_sign = s1_sx[32];
                    s1_frac = {21'd0, s1_mag[31:0]};
                end
                FMT_F32: s1_byp = i_in.data.native_sample[31:0];
                FMT_F64: begin
                    if (s1_e == 11'h7FF) begin
                        if (i_in.data.native_sample[51:0] == 52'd0)
                            s1_byp = {s1_sign, 31'h7F800000};
                        else
                            // quiet bit forced, top payload bits below it
                            s1_byp = {s1_sign, 9'h1FF, i_in.data.native_sample[50:29]};
                    end else if (s1_e >= 11'd1151) begin
                        s1_byp = {s1_sign, 31'h7F800000};
                    end else if (s1_e < 11'd866) begin
                        s1_byp = {s1_sign, 31'd0};
                    end else begin
                        s1_kind = K_F64;
                    end
                end
                default: ;
            endcase
        end

        // Encode clamp to [-1,1]; NaN untouched
        s1_emag = i_in.data.float_sample[30:0];
        s1_nan  = s1_emag > 31'h7F800000;
        if (!s1_nan && s1_emag > 31'h3F800000) s1_emag = 31'h3F800000;
    end

    logic        r_v1, r_func1, r_sign1, r_nan1;
    logic [2:0]  r_fmt1;
    logic [1:0]  r_kind1;
    logic [31:0] r_byp1;
    logic [52:0] r_frac1;
    logic [7:0]  r_ebase1;
    logic [10:0] r_e1;
    logic [30:0] r_emag1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func1  <= i_in.data.func;
            r_fmt1   <= i_in.data.sample_format;
            r_sign1  <= s1_sign;
            r_kind1  <= s1_kind;
            r_byp1   <= s1_byp;
            r_frac1  <= s1_frac;
            r_ebase1 <= s1_ebase;
            r_e1     <= s1_e;
            r_emag1  <= s1_emag;
            r_nan1   <= s1_nan;
        end
    end

    // ---------------- stage 2: leading one / scale ----------------
    logic [1:0]  s2_kind;
    logic [31:0] s2_byp;
    logic [4:0]  s2_p, s2_shl, s2_shr;
    logic [7:0]  s2_eb, s2_ee, s2_rs;
    logic [23:0] s2_m;
    logic [55:0] s2_m56, s2_prod;
    logic [63:0] s2_nbyp;

    always_comb begin
        s2_kind = r_kind1;
        s2_byp  = r_byp1;
        s2_p    = f_msb32(r_frac1[31:0]);
        s2_shl  = 5'd0;
        s2_shr  = 5'd0;
        s2_eb   = 8'd0;
        if (r_kind1 == K_INT) begin
            if (r_frac1[31:0] == 32'd0) begin
                s2_kind = K_BYP;
                s2_byp  = 32'd0;
            end
            s2_eb  = r_ebase1 + {3'd0, s2_p};
            s2_shl = 5'd31 - s2_p;
        end else if (r_e1 >= 11'd897) begin
            s2_eb = 8'(r_e1 - 11'd897);
        end else begin
            s2_shr = 5'(11'd897 - r_e1);
        end

        // Encode: mag * c as a shift, minus mag for I16 and I24
        s2_ee  = r_emag1[30:23];
        s2_m   = {(s2_ee != 8'd0), r_emag1[22:0]};
        s2_rs  = (s2_ee == 8'd0) ? 8'd149 : (8'd150 - s2_ee);
        s2_m56 = {32'd0, s2_m};
        case (r_fmt1)
            FMT_I16: s2_prod = (s2_m56 << 15) - s2_m56;
            FMT_I24: s2_prod = (s2_m56 << 23) - s2_m56;
            FMT_I32: s2_prod = s2_m56 << 31;
            default: s2_prod = 56'd0;
        endcase
        case (r_fmt1)
            FMT_F32: s2_nbyp = {32'd0, r_sign1, r_emag1};
            FMT_F64: s2_nbyp = f_f32_to_f64({r_sign1, r_emag1});
            default: s2_nbyp = 64'd0;
        endcase
    end

    logic        r_v2, r_func2, r_sign2, r_nan2;
    logic [2:0]  r_fmt2;
    logic [1:0]  r_kind2;
    logic [31:0] r_byp2;
    logic [52:0] r_frac2;
    logic [7:0]  r_eb2, r_rs2;
    logic [4:0]  r_shl2, r_shr2;
    logic [55:0] r_prod2;
    logic [63:0] r_nbyp2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func2 <= r_func1;
            r_fmt2  <= r_fmt1;
            r_sign2 <= r_sign1;
            r_nan2  <= r_nan1;
            r_kind2 <= s2_kind;
            r_byp2  <= s2_byp;
            r_frac2 <= r_frac1;
            r_eb2   <= s2_eb;
            r_shl2  <= s2_shl;
            r_shr2  <= s2_shr;
            r_rs2   <= s2_rs;
            r_prod2 <= s2_prod;
            r_nbyp2 <= s2_nbyp;
        end
    end

    // ---------------- stage 3: align ----------------
    logic [52:0] s3_w;
    logic        s3_sticky;
    logic [5:0]  s3_lz;

    always_comb begin
        if (r_kind2 == K_INT) begin
            s3_w      = {r_frac2[31:0] << r_shl2, 21'd0};
            s3_sticky = 1'b0;
        end else begin
            s3_w      = r_frac2 >> r_shr2;
            s3_sticky = |(r_frac2 & ~({53{1'b1}} << r_shr2));
        end
        s3_lz = 6'd56 - f_blen56(r_prod2);
    end

    logic        r_v3, r_func3, r_sign3, r_nan3, r_sticky3;
    logic [2:0]  r_fmt3;
    logic [1:0]  r_kind3;
    logic [31:0] r_byp3;
    logic [52:0] r_w3;
    logic [7:0]  r_eb3, r_rs3;
    logic [5:0]  r_lz3;
    logic [55:0] r_prod3;
    logic [63:0] r_nbyp3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func3   <= r_func2;
            r_fmt3    <= r_fmt2;
            r_sign3   <= r_sign2;
            r_nan3    <= r_nan2;
            r_kind3   <= r_kind2;
            r_byp3    <= r_byp2;
            r_w3      <= s3_w;
            r_sticky3 <= s3_sticky;
            r_eb3     <= r_eb2;
            r_rs3     <= r_rs2;
            r_lz3     <= s3_lz;
            r_prod3   <= r_prod2;
            r_nbyp3   <= r_nbyp2;
        end
    end

    // ---------------- stage 4: round ----------------
    logic        s4_inc, s4_einc;
    logic [24:0] s4_mant, s4_r25;
    logic [30:0] s4_mag;
    logic [31:0] s4_fres;
    logic [55:0] s4_nrm;
    logic [8:0]  s4_ts;

    always_comb begin
        // Nearest even at bit 29 of the aligned word
        s4_inc  = r_w3[28] & (r_w3[29] | (|r_w3[27:0]) | r_sticky3);
        s4_mant = {1'b0, r_w3[52:29]} + {24'd0, s4_inc};
        s4_mag  = {r_eb3, 23'd0} + {6'd0, s4_mant};
        s4_fres = (r_kind3 == K_BYP) ? r_byp3 : {r_sign3, s4_mag};

        // Product rounded to 24 significant bits
        s4_nrm  = r_prod3 << r_lz3;
        s4_einc = s4_nrm[31] & (s4_nrm[32] | (|s4_nrm[30:0]));
        s4_r25  = {1'b0, s4_nrm[55:32]} + {24'd0, s4_einc};
        s4_ts   = {3'd0, r_lz3} + {1'b0, r_rs3};
    end

    logic        r_v4, r_func4, r_sign4, r_nan4;
    logic [2:0]  r_fmt4;
    logic [31:0] r_fres4;
    logic [24:0] r_r25_4;
    logic [8:0]  r_ts4;
    logic [63:0] r_nbyp4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func4 <= r_func3;
            r_fmt4  <= r_fmt3;
            r_sign4 <= r_sign3;
            r_nan4  <= r_nan3;
            r_fres4 <= s4_fres;
            r_r25_4 <= s4_r25;
            r_ts4   <= s4_ts;
            r_nbyp4 <= r_nbyp3;
        end
    end

    // ---------------- stage 5: truncate, saturate, sign ----------------
    logic [56:0] s5_x;
    logic [31:0] s5_n, s5_sn;
    t_out_item   s5_out;

    always_comb begin
        s5_x = {r_r25_4, 32'd0} >> r_ts4;
        s5_n = r_nan4 ? 32'd0 : s5_x[31:0];
        if (r_fmt4 == FMT_I32 && !r_sign4 && s5_n[31]) s5_n = 32'h7FFFFFFF;
        s5_sn = r_sign4 ? (32'd0 - s5_n) : s5_n;

        s5_out.float_result  = 32'd0;
        s5_out.native_result = 64'd0;
        s5_out.native_valid  = 1'b0;
        if (r_func4 == FUNC_DECODE) begin
            s5_out.float_result = r_fres4;
        end else begin
            s5_out.native_valid = 1'b1;
            case (r_fmt4)
                FMT_I16: s5_out.native_result = {48'd0, s5_sn[15:0]};
                FMT_I24: s5_out.native_result = {40'd0, s5_sn[23:0]};
                FMT_I32: s5_out.native_result = {32'd0, s5_sn};
                FMT_F32, FMT_F64: s5_out.native_result = r_nbyp4;
                default: s5_out.native_valid = 1'b0;
            endcase
        end
    end

    logic      r_v5, r_func5;
    logic [2:0] r_fmt5;
    t_out_item r_out5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out5  <= s5_out;
            r_func5 <= r_func4;
            r_fmt5  <= r_fmt4;
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign o_out.valid = r_v5;
    assign o_out.data  = r_out5;

    // ---------------- assertions ----------------
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted item did not enter stage 1");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !o_out.ready) |=> $stable({r_v1, r_v2, r_v3, r_v4, r_v5}))
        else $error("pipeline moved during a stall");

    a_decode_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_func5 == FUNC_DECODE) |->
        (!r_out5.native_valid && r_out5.native_result == 64'd0))
        else $error("decode item flagged a native store");

    a_encode_float_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_func5 == FUNC_ENCODE) |->
        (r_out5.float_result == 32'd0 &&
         r_out5.native_valid == (r_fmt5 <= FMT_F64)))
        else $error("encode item has bad float result or store flag");

endmodule

/* tb/sv/pcm_float_sample_converter_top_tb.sv */
`timescale 1ns / 1ps

module pcm_float_sample_converter_top_tb;
    import pfsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int N_RANDOM       = 924;

    logic i_clk;
    logic i_rst_n;

    pfsc_in_if  in_ch ();
    pfsc_out_if out_ch ();

    pcm_float_sample_converter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_in_item  sample_q[$];
    t_out_item conv_expect_q[$];
    int        n_errors;
    bit        stim_done;
    bit        hold_tx;
    int        burst_left;
    int        gap_left;
    int        stall_phase;
    int        idle_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Bit length of a value
    function automatic int bit_len(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = i + 1;
        end
        return n;
    endfunction

    // Shift right by sh (1..63) with round to nearest even
    function automatic logic [63:0] rne_shift(input logic [63:0] v, input int sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        q    = v >> sh;
        rem  = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        return q;
    endfunction

    // Signed integer magnitude times 2^-k as binary32
    function automatic logic [31:0] int_scale_f32(input logic [63:0] mag, input bit neg,
                                                  input int k);
        int          p;
        logic [63:0] mant;
        logic [31:0] ex;
        if (mag == 64'd0) return 32'd0;
        p = bit_len(mag) - 1;
        if (p <= 23) begin
            mant = mag << (23 - p);
        end else begin
            mant = rne_shift(mag, p - 23);
            if (mant == (64'd1 << 24)) begin
                mant = mant >> 1;
                p++;
            end
        end
        ex = 32'(p - k + 127);
        return {neg, 31'd0} | (ex << 23) | {9'd0, mant[22:0]};
    endfunction

    // Binary64 narrowed to binary32
    function automatic logic [31:0] narrow_f64(input logic [63:0] d);
        logic [31:0] sgn;
        int          e;
        int          e32;
        int          sh;
        logic [51:0] f;
        logic [63:0] m;
        logic [63:0] mant;
        sgn = {d[63], 31'd0};
        e   = int'(d[62:52]);
        f   = d[51:0];
        if (e == 2047) begin
            if (f == 52'd0) return sgn | 32'h7F80_0000;
            return sgn | 32'h7FC0_0000 | 32'(f >> 29);
        end
        if (e == 0) return sgn;
        m   = {11'd0, 1'b1, f};
        e32 = e - 896;
        if (e32 >= 255) return sgn | 32'h7F80_0000;
        if (e32 >= 1) begin
            mant = rne_shift(m, 29);
            if (mant == (64'd1 << 24)) begin
                mant = mant >> 1;
                e32++;
            end
            if (e32 >= 255) return sgn | 32'h7F80_0000;
            return sgn | (32'(e32) << 23) | {9'd0, mant[22:0]};
        end
        sh = 29 + (1 - e32);
        if (sh > 60) return sgn;
        mant = rne_shift(m, sh);
        return sgn | mant[31:0];
    endfunction

    // Binary32 widened to binary64
    function automatic logic [63:0] widen_f32(input logic [31:0] x);
        logic [63:0] sgn;
        logic [63:0] f;
        int          e;
        int          p;
        sgn = {x[31], 63'd0};
        e   = int'(x[30:23]);
        f   = {41'd0, x[22:0]};
        if (e == 255) begin
            if (f == 64'd0) return sgn | 64'h7FF0_0000_0000_0000;
            return sgn | 64'h7FF8_0000_0000_0000 | (f << 29);
        end
        if (e == 0) begin
            if (f == 64'd0) return sgn;
            p = bit_len(f) - 1;
            return sgn | (64'(p + 874) << 52) | ((f << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF);
        end
        return sgn | (64'(e + 896) << 52) | (f << 29);
    endfunction

    // trunc(round32(mag * c)) for a magnitude no larger than 1.0
    function automatic logic [63:0] scaled_trunc(input logic [31:0] mag, input logic [63:0] c);
        int          e;
        int          rs;
        int          len;
        logic [63:0] m;
        logic [63:0] prod;
        e = int'(mag[30:23]);
        m = {41'd0, mag[22:0]};
        if (e == 0) begin
            rs = 149;
        end else begin
            m  = m | 64'h80_0000;
            rs = 150 - e;
        end
        prod = m * c;
        len  = bit_len(prod);
        if (len > 24) prod = rne_shift(prod, len - 24) << (len - 24);
        if (rs >= 64) return 64'd0;
        return prod >> rs;
    endfunction

    // Expected result for one sample
    function automatic t_out_item convert_sample(input t_in_item it);
        t_out_item   r;
        logic [63:0] raw;
        logic [63:0] n;
        logic [31:0] mag;
        logic [31:0] v;
        bit          neg;
        bit          nan;
        r = '0;
        if (it.func == FUNC_DECODE) begin
            case (it.sample_format)
                FMT_I16: begin
                    raw = {48'd0, it.native_sample[15:0]};
                    neg = raw[15];
                    r.float_result = int_scale_f32(neg ? 64'h1_0000 - raw : raw, neg, 15);
                end
                FMT_I24: begin
                    raw = {40'd0, it.native_sample[23:0]};
                    neg = raw[23];
                    r.float_result = int_scale_f32(neg ? 64'h100_0000 - raw : raw, neg, 23);
                end
                FMT_I32: begin
                    raw = {32'd0, it.native_sample[31:0]};
                    neg = raw[31];
                    r.float_result = int_scale_f32(neg ? 64'h1_0000_0000 - raw : raw, neg, 31);
                end
                FMT_F32: r.float_result = it.native_sample[31:0];
                FMT_F64: r.float_result = narrow_f64(it.native_sample);
                default: r.float_result = 32'd0;
            endcase
        end else begin
            mag = {1'b0, it.float_sample[30:0]};
            neg = it.float_sample[31];
            nan = mag > 32'h7F80_0000;
            v   = it.float_sample;
            // clamp to [-1,1], NaN left alone
            if (!nan && mag > 32'h3F80_0000) begin
                mag = 32'h3F80_0000;
                v   = {neg, 31'd0} | mag;
            end
            r.native_valid = 1'b1;
            case (it.sample_format)
                FMT_I16: begin
                    n = nan ? 64'd0 : scaled_trunc(mag, 64'd32767);
                    r.native_result = (neg ? -n : n) & 64'hFFFF;
                end
                FMT_I24: begin
                    n = nan ? 64'd0 : scaled_trunc(mag, 64'd8388607);
                    r.native_result = (neg ? -n : n) & 64'hFF_FFFF;
                end
                FMT_I32: begin
                    n = nan ? 64'd0 : scaled_trunc(mag, 64'h8000_0000);
                    if (!neg && n > 64'h7FFF_FFFF) n = 64'h7FFF_FFFF;
                    r.native_result = (neg ? -n : n) & 64'hFFFF_FFFF;
                end
                FMT_F32: r.native_result = {32'd0, v};
                FMT_F64: r.native_result = widen_f32(v);
                default: r.native_valid = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic t_in_item mk_sample(input logic fn, input logic [2:0] fmt,
                                           input logic [63:0] ns, input logic [31:0] fs);
        t_in_item it;
        it.func          = fn;
        it.sample_format = fmt;
        it.native_sample = ns;
        it.float_sample  = fs;
        return it;
    endfunction

    // Random float32 leaning on the interesting ranges
    function automatic logic [31:0] rand_f32();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 5))
            0: x[30:23] = 8'($urandom_range(100, 127));
            1: x[30:23] = 8'($urandom_range(120, 126));
            2: x[30:23] = 8'd0;
            3: x[30:23] = 8'hFF;
            4: x = {x[31], 31'h3F80_0000};
            default: ;
        endcase
        return x;
    endfunction

    function automatic logic [63:0] rand_f64();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: d[62:52] = 11'($urandom_range(1000, 1030));
            1: d[62:52] = 11'($urandom_range(860, 900));
            2: d[62:52] = 11'($urandom_range(1140, 1160));
            3: d[62:52] = 11'h7FF;
            4: d[62:52] = 11'd0;
            default: ;
        endcase
        return d;
    endfunction

    // Stimulus
    initial begin
        logic [31:0] fvals[$];
        logic [63:0] nvals[$];
        t_in_item    it;
        n_errors  = 0;
        stim_done = 1'b0;
        hold_tx   = 1'b0;

        // directed: extremes of integers, special floats, every format incl. unknown
        nvals = '{64'h0, 64'h7FFF, 64'h8000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7F_FFFF,
                  64'h80_0000, 64'h7FFF_FFFF, 64'h8000_0000, 64'h7FF8_0000_0000_0001,
                  64'h47EF_FFFF_F000_0000, 64'h3690_0000_0000_0001};
        foreach (nvals[i]) begin
            for (int f = 0; f < 8; f++) sample_q.push_back(mk_sample(FUNC_DECODE, 3'(f),
                                                                      nvals[i], 32'd0));
        end
        fvals = '{32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                  32'h7FC0_0001, 32'hFFA0_0000, 32'h8000_0000, 32'h0000_0001,
                  32'h3F7F_FFFF, 32'h4000_0000, 32'hFFFF_FFFF};
        foreach (fvals[i]) begin
            for (int f = 0; f < 8; f++) sample_q.push_back(mk_sample(FUNC_ENCODE, 3'(f),
                                                                      {$urandom, $urandom},
                                                                      fvals[i]));
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            it = mk_sample(1'($urandom), 3'($urandom_range(0, 7)), {$urandom, $urandom},
                           rand_f32());
            if (it.sample_format == FMT_F64 && $urandom_range(0, 1)) it.native_sample = rand_f64();
            if (it.sample_format == FMT_F32 && $urandom_range(0, 1))
                it.native_sample[31:0] = rand_f32();
            sample_q.push_back(it);
            // hold the sender once until the pipeline drains
            if (i == N_RANDOM / 2) begin
                wait (sample_q.size() == 0);
                hold_tx = 1'b1;
                wait (!in_ch.valid && conv_expect_q.size() == 0);
                @(posedge i_clk);
                hold_tx <= 1'b0;
            end
        end
        stim_done = 1'b1;
    end

    // Reset
    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: bursts with random gaps
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        burst_left  = 0;
        gap_left    = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                conv_expect_q.push_back(convert_sample(in_ch.data));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left    <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (sample_q.size() > 0 && !hold_tx) begin
                    in_ch.data  <= sample_q.pop_front();
                    in_ch.valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: receiver stall pattern and result check
    initial begin
        out_ch.ready = 1'b0;
        stall_phase  = 0;
        idle_cycles  = 0;
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        stall_phase <= stall_phase + 1;
        // stretches of full throughput, then patterned stalls
        if ((stall_phase / 64) % 3 == 0) out_ch.ready <= 1'b1;
        else out_ch.ready <= ((stall_phase % 5) != 2) && ($urandom_range(0, 3) != 0);

        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            idle_cycles <= 0;
            if (conv_expect_q.size() == 0) begin
                $display("%0t: unexpected result float=%h native=%h nv=%b", $time,
                         out_ch.data.float_result, out_ch.data.native_result,
                         out_ch.data.native_valid);
                n_errors++;
            end else begin
                exp_r = conv_expect_q.pop_front();
                if (out_ch.data.float_result !== exp_r.float_result) begin
                    $display("%0t: float_result expected %h actual %h", $time,
                             exp_r.float_result, out_ch.data.float_result);
                    n_errors++;
                end
                if (out_ch.data.native_result !== exp_r.native_result) begin
                    $display("%0t: native_result expected %h actual %h", $time,
                             exp_r.native_result, out_ch.data.native_result);
                    n_errors++;
                end
                if (out_ch.data.native_valid !== exp_r.native_valid) begin
                    $display("%0t: native_valid expected %b actual %b", $time,
                             exp_r.native_valid, out_ch.data.native_valid);
                    n_errors++;
                end
            end
        end else if (in_ch.valid && in_ch.ready) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run and watchdog
    initial begin
        wait (i_rst_n);
        fork
            begin
                wait (stim_done && sample_q.size() == 0 && !in_ch.valid
                      && conv_expect_q.size() == 0);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         conv_expect_q.size());
                n_errors++;
            end
        join_any
        if (n_errors == 0 && conv_expect_q.size() == 0) begin
            $display("pcm_float_sample_converter_top test passed");
        end else begin
            if (conv_expect_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         conv_expect_q.size());
            $display("pcm_float_sample_converter_top test failed");
        end
        $finish;
    end

endmodule
